// ===== hdl/go_back_n_sender_window_macros.svh =====
// Assertion macros shared by the sender window RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef GO_BACK_N_SENDER_WINDOW_MACROS_SVH
`define GO_BACK_N_SENDER_WINDOW_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GBSW_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gbsw check failed");

// Next-cycle implication, disabled during reset.
`define GBSW_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gbsw check failed");

`endif

// ===== hdl/gbsw_pkg.sv =====
// Shared types and constants for the Go-Back-N sender window.
// No dependencies; used by every module of the block.
package gbsw_pkg;

   localparam int SEQ_W   = 32;
   localparam int CNT_W   = 6;   // burst length, holds up to 63
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = 2;
   localparam int CSR_IDX_W = 3;

   localparam logic [5:0]  RST_WINDOW   = 6'd4;
   localparam logic [23:0] RST_TIMEOUT  = 24'd100000;
   localparam logic        RST_ADAPTIVE = 1'b0;
   localparam logic [7:0]  RST_MAX_TO   = 8'd10;
   localparam logic [31:0] RST_TOTAL    = 32'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ADAPTIVE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TO   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL    = 3'd4;

   localparam logic [1:0] STATUS_RUN   = 2'd0;
   localparam logic [1:0] STATUS_DONE  = 2'd1;
   localparam logic [1:0] STATUS_ABORT = 2'd2;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_ACK   = 2'd1,
      KIND_START = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_RUN   = 4'b0010,
      PH_DONE  = 4'b0100,
      PH_ABORT = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [5:0]  window_size;
      logic [23:0] timeout_ticks;
      logic        adaptive_enable;
      logic [7:0]  max_timeouts;
      logic [31:0] total_segments;
   } cfg_type;

   // One entry per accepted item: an optional new segment, then an
   // optional retransmit burst; neither means a status-only beat.
   typedef struct packed {
      logic             new_valid;
      logic [SEQ_W-1:0] new_seq;
      logic [SEQ_W-1:0] burst_seq;
      logic [CNT_W-1:0] burst_cnt;
      logic [1:0]       status;
   } job_type;

endpackage

// ===== hdl/gbsw_front.sv =====
// Front end: takes one item a cycle, updates window/timer/RTT state and
// builds the job for the back end. Depends on gbsw_pkg.
module gbsw_front #(
   parameter int MAX_WINDOW = 32,
   parameter int TIME_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  gbsw_pkg::cfg_type       cfg,
   input  logic                    item_valid,
   input  logic [1:0]              item_kind,
   input  logic [31:0]             item_ack_seq,
   input  logic                    item_ack_last,
   output gbsw_pkg::job_type       job
);
   import gbsw_pkg::*;

   localparam int RW = (TIME_WIDTH > 35) ? TIME_WIDTH : 35;
   localparam logic [TIME_WIDTH-1:0] TMAX = {TIME_WIDTH{1'b1}};
   localparam logic [RW-1:0] TMAX_RW = RW'(TMAX);
   localparam logic [5:0] MAXW6 = 6'(MAX_WINDOW);

   logic [31:0] base_ff, base_in, next_ff, next_in, tbase_ff, tbase_in;
   logic [31:0] sseq_ff, sseq_in, est_ff, est_in, dev_ff, dev_in, scount_ff, scount_in;
   logic [TIME_WIDTH-1:0] timer_ff, timer_in;
   logic        run_ff, run_in, srst_ff, srst_in;
   logic [7:0]  tcount_ff, tcount_in;
   phase_type   phase_ff, phase_in;

   logic [5:0]  win6;
   logic [31:0] win32;
   logic [RW-1:0] rto;

   always_comb begin
      win6 = cfg.window_size;
      if (win6 == 6'd0) win6 = 6'd1;
      if (win6 > MAXW6) win6 = MAXW6;
      win32 = 32'(win6);
   end

   // est + 4*dev in adaptive mode, else the configured timeout; saturated to the timer range, floor of one tick
   always_comb begin
      if (cfg.adaptive_enable) rto = RW'(est_ff) + (RW'(dev_ff) << 2);
      else rto = RW'(cfg.timeout_ticks);
      if (rto > TMAX_RW) rto = TMAX_RW;
      if (rto == '0) rto = RW'(1);
   end

   always_comb begin
      logic [31:0] d, outst, cnt32, err;
      logic [33:0] dev_sum;
      logic [34:0] est_sum;
      logic        resend;
      d = '0; outst = '0; cnt32 = '0; err = '0; dev_sum = '0; est_sum = '0;
      resend = 1'b1;
      base_in = base_ff; next_in = next_ff; tbase_in = tbase_ff; sseq_in = sseq_ff;
      est_in = est_ff; dev_in = dev_ff; scount_in = scount_ff; timer_in = timer_ff;
      run_in = run_ff; srst_in = srst_ff; tcount_in = tcount_ff; phase_in = phase_ff;
      job = '0;
      if (item_valid) begin
         unique case (kind_type'(item_kind))
            KIND_START: begin
               base_in = 32'd1; next_in = 32'd1; timer_in = '0; run_in = 1'b0;
               tcount_in = 8'd0; tbase_in = 32'd1; est_in = 32'(cfg.timeout_ticks);
               dev_in = '0; scount_in = '0; sseq_in = 32'd1; srst_in = 1'b1;
               phase_in = PH_RUN;
            end
            KIND_TICK: if (phase_ff == PH_RUN) begin
               if (run_in && timer_in != TMAX) timer_in = timer_in + 1'b1;
               if (cfg.adaptive_enable && !srst_in && scount_in != '1)
                  scount_in = scount_in + 32'd1;
               if ((next_in - base_in) < win32 &&
                   (next_in - 32'd1) < cfg.total_segments) begin
                  job.new_valid = 1'b1;
                  job.new_seq = next_in;
                  if (cfg.adaptive_enable && srst_in) begin
                     sseq_in = next_in; scount_in = '0; srst_in = 1'b0;
                  end
                  if (base_in == next_in) begin
                     timer_in = '0; run_in = 1'b1;
                  end
                  next_in = next_in + 32'd1;
               end
               if (run_in && RW'(timer_in) >= rto) begin
                  if (base_in == tbase_in) begin
                     if (tcount_in >= cfg.max_timeouts) resend = 1'b0;
                     if (tcount_in != 8'hFF) tcount_in = tcount_in + 8'd1;
                  end else begin
                     tcount_in = 8'd1; tbase_in = base_in;
                  end
                  if (!resend) begin
                     phase_in = PH_ABORT; run_in = 1'b0; timer_in = '0;
                  end else begin
                     cnt32 = next_in - base_in;
                     if (cnt32 > win32) cnt32 = win32;
                     timer_in = '0; run_in = 1'b1;
                     if (cnt32 != 32'd0) begin
                        job.burst_seq = base_in;
                        job.burst_cnt = CNT_W'(cnt32);
                        if (cfg.adaptive_enable && srst_in) begin
                           sseq_in = base_in; scount_in = '0; srst_in = 1'b0;
                        end
                     end
                     next_in = base_in + cnt32;
                  end
               end
            end
            KIND_ACK: if (phase_ff == PH_RUN) begin
               if (item_ack_last) begin
                  phase_in = PH_DONE; run_in = 1'b0; timer_in = '0;
               end else begin
                  d = item_ack_seq - base_ff;
                  outst = next_ff - base_ff;
                  if (d < outst) begin
                     if (cfg.adaptive_enable && !srst_ff && (sseq_ff - base_ff) <= d) begin
                        err = (scount_ff >= est_ff) ? scount_ff - est_ff : est_ff - scount_ff;
                        dev_sum = 34'(dev_ff) + {1'b0, dev_ff, 1'b0} + 34'(err);
                        dev_in = dev_sum[33:2];
                        est_sum = {est_ff, 3'b000} - 35'(est_ff) + 35'(scount_ff);
                        est_in = est_sum[34:3];
                        sseq_in = item_ack_seq; srst_in = 1'b1;
                     end
                     base_in = item_ack_seq + 32'd1;
                     timer_in = '0;
                     run_in = (base_in != next_ff);
                  end
               end
            end
            default: ;
         endcase
      end
      unique case (phase_in)
         PH_DONE:  job.status = STATUS_DONE;
         PH_ABORT: job.status = STATUS_ABORT;
         default:  job.status = STATUS_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= 32'd1; next_ff <= 32'd1; tbase_ff <= 32'd1; sseq_ff <= 32'd1;
         est_ff <= 32'(RST_TIMEOUT); dev_ff <= '0; scount_ff <= '0; timer_ff <= '0;
         run_ff <= 1'b0; srst_ff <= 1'b1; tcount_ff <= 8'd0; phase_ff <= PH_IDLE;
      end else begin
         base_ff <= base_in; next_ff <= next_in; tbase_ff <= tbase_in; sseq_ff <= sseq_in;
         est_ff <= est_in; dev_ff <= dev_in; scount_ff <= scount_in; timer_ff <= timer_in;
         run_ff <= run_in; srst_ff <= srst_in; tcount_ff <= tcount_in; phase_ff <= phase_in;
      end
   end

endmodule

// ===== hdl/gbsw_queue.sv =====
// Short job queue between front and back end.
// Depends on gbsw_pkg.
module gbsw_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gbsw_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output gbsw_pkg::job_type head,
   output logic              empty
);
   import gbsw_pkg::*;

   job_type             slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]     cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full  = (cnt_ff == (QPTR_W+1)'(QDEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = slot_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_job;
   end

endmodule

// ===== hdl/gbsw_back.sv =====
// Back end: expands queued jobs into result beats, one per cycle while the result register is free or
// being popped, into the result register. Depends on gbsw_pkg and the assertion macros.
`include "go_back_n_sender_window_macros.svh"
module gbsw_back (
   input  logic              clock,
   input  logic              reset,
   input  logic [31:0]       total_segments,
   input  gbsw_pkg::job_type head,
   input  logic              q_empty,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic              rsp_has_segment,
   output logic [31:0]       rsp_seq_out,
   output logic              rsp_segment_is_last,
   output logic              rsp_is_retransmit,
   output logic [1:0]        rsp_status,
   output logic              rsp_end_of_run
);
   import gbsw_pkg::*;

   logic             first_done_ff, first_done_in;
   logic [CNT_W-1:0] sent_ff, sent_in;
   logic             valid_ff, valid_in;
   logic             has_ff, retx_ff, last_seg_ff, eor_ff;
   logic [31:0]      seq_ff;
   logic [1:0]       status_ff;

   logic             emit, beat_has, beat_retx, beat_last, beat_new;
   logic [31:0]      beat_seq;

   assign emit = !q_empty && (!valid_ff || rsp_pop);

   always_comb begin
      beat_new = 1'b0; beat_has = 1'b0; beat_retx = 1'b0; beat_seq = '0; beat_last = 1'b1;
      if (head.new_valid && !first_done_ff) begin
         beat_new = 1'b1; beat_has = 1'b1; beat_seq = head.new_seq;
         beat_last = (head.burst_cnt == '0);
      end else if (head.burst_cnt != '0) begin
         beat_has = 1'b1; beat_retx = 1'b1;
         beat_seq = head.burst_seq + 32'(sent_ff);
         beat_last = (sent_ff == head.burst_cnt - 1'b1);
      end
   end

   assign q_pop = emit && beat_last;

   always_comb begin
      first_done_in = first_done_ff;
      sent_in = sent_ff;
      if (emit) begin
         if (beat_last) begin
            first_done_in = 1'b0; sent_in = '0;
         end else if (beat_new) first_done_in = 1'b1;
         else sent_in = sent_ff + 1'b1;
      end
      valid_in = emit ? 1'b1 : (rsp_pop ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_done_ff <= 1'b0; sent_ff <= '0; valid_ff <= 1'b0;
      end else begin
         first_done_ff <= first_done_in; sent_ff <= sent_in; valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         has_ff      <= beat_has;
         seq_ff      <= beat_seq;
         last_seg_ff <= beat_has && (beat_seq == total_segments);
         retx_ff     <= beat_retx;
         status_ff   <= head.status;
         eor_ff      <= beat_last;
      end
   end

   assign rsp_empty           = !valid_ff;
   assign rsp_has_segment     = has_ff;
   assign rsp_seq_out         = seq_ff;
   assign rsp_segment_is_last = last_seg_ff;
   assign rsp_is_retransmit   = retx_ff;
   assign rsp_status          = status_ff;
   assign rsp_end_of_run      = eor_ff;

   `GBSW_ASSERT_IMP(a_retx_in_burst, clock, reset, emit && beat_retx, sent_ff < head.burst_cnt)
   `GBSW_ASSERT_IMP(a_status_only_ends, clock, reset, emit && !beat_has, beat_last)
   `GBSW_ASSERT_NXT(a_progress_clear, clock, reset, emit && beat_last, sent_ff == '0 && !first_done_ff)

endmodule

// ===== hdl/go_back_n_sender_window.sv =====
// Go-Back-N sender window: accepts one tick/ack/start beat per cycle while the job queue has room.
// A result beat passes from its input beat through a job queue slot and then the result register onto rsp_*.
// Throughput: one input beat per cycle; results drain one beat per cycle while rsp_pop keeps pace, so a timeout
// burst of up to window+1 beats holds the back end while the 4-entry job queue takes further jobs.
// Reset (synchronous, active high): config registers return to defaults, phase idle, queue empty.
// Depends on gbsw_pkg, gbsw_front, gbsw_queue, gbsw_back.
module go_back_n_sender_window #(
   parameter int MAX_WINDOW = 32,
   parameter int TIME_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_ack_seq,
   input  logic        req_ack_last,
   // result channel
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_has_segment,
   output logic [31:0] rsp_seq_out,
   output logic        rsp_segment_is_last,
   output logic        rsp_is_retransmit,
   output logic [1:0]  rsp_status,
   output logic        rsp_end_of_run,
   // configuration
   input  logic        csr_write,
   input  logic [gbsw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0] csr_wdata
);
   import gbsw_pkg::*;

   cfg_type cfg_ff, cfg_in;
   job_type fe_job, q_head;
   logic    accept, q_empty, q_pop;

   // Configuration registers; to be written only while the block is quiet (the block does not enforce this).
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_WINDOW:   cfg_in.window_size     = csr_wdata[5:0];
            CSR_TIMEOUT:  cfg_in.timeout_ticks   = csr_wdata[23:0];
            CSR_ADAPTIVE: cfg_in.adaptive_enable = csr_wdata[0];
            CSR_MAX_TO:   cfg_in.max_timeouts    = csr_wdata[7:0];
            CSR_TOTAL:    cfg_in.total_segments  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_size     <= RST_WINDOW;
         cfg_ff.timeout_ticks   <= RST_TIMEOUT;
         cfg_ff.adaptive_enable <= RST_ADAPTIVE;
         cfg_ff.max_timeouts    <= RST_MAX_TO;
         cfg_ff.total_segments  <= RST_TOTAL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Every accepted beat yields exactly one job, so acceptance is gated by queue room.
   assign accept = req_push && !req_full;

   gbsw_front #(
      .MAX_WINDOW (MAX_WINDOW),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .item_valid    (accept),
      .item_kind     (req_kind),
      .item_ack_seq  (req_ack_seq),
      .item_ack_last (req_ack_last),
      .job           (fe_job)
   );

   gbsw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_job (fe_job),
      .full     (req_full),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty)
   );

   // Back end expands each job into its new segment, retransmits or status beat.
   gbsw_back u_back (
      .clock               (clock),
      .reset               (reset),
      .total_segments      (cfg_ff.total_segments),
      .head                (q_head),
      .q_empty             (q_empty),
      .q_pop               (q_pop),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_has_segment     (rsp_has_segment),
      .rsp_seq_out         (rsp_seq_out),
      .rsp_segment_is_last (rsp_segment_is_last),
      .rsp_is_retransmit   (rsp_is_retransmit),
      .rsp_status          (rsp_status),
      .rsp_end_of_run      (rsp_end_of_run)
   );

endmodule
